### design/flpf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the fixed-length packet framer
package flpf_pkg;

	localparam int PACKET_BYTES = 16;
	localparam int REPLY_BYTES = 3;
	localparam int IDX_W = $clog2(PACKET_BYTES);

	localparam logic [7:0] TIMEOUT_RESET = 8'd10;
	localparam logic REG_TIMEOUT_RELOAD = 1'b0;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_SEND = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_REPLY = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	typedef struct packed {
		op_t op;
		logic [7:0] data;
		logic [IDX_W-1:0] rd_idx;
		logic rd_in_range;
	} entry_t;

	typedef struct packed {
		logic valid;
		entry_t entry;
	} queue_head_t;

endpackage

### design/flpf_front.sv
`timescale 1ns / 1ps
// request intake: decodes each request and queues it for the executor
module flpf_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] command,
	input logic [7:0] rx_byte,
	input logic [7:0] reply_byte,
	input logic [3:0] read_index,
	output flpf_pkg::queue_head_t head,
	input logic pop
);
	import flpf_pkg::*;

	entry_t entry_d;
	entry_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;

	always_comb begin
		entry_d.op = op_t'(command);
		entry_d.data = (op_t'(command) == OP_SEND) ? reply_byte : rx_byte;
		entry_d.rd_idx = IDX_W'(read_index);
		entry_d.rd_in_range = 32'(read_index) < PACKET_BYTES;
	end

	assign in_ready = count_q != 2'd2;
	assign push = in_valid && in_ready;
	assign head.valid = count_q != 2'd0;
	assign head.entry = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= entry_d;
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("queue popped while empty");

endmodule

### design/flpf_back.sv
`timescale 1ns / 1ps
// executor: framing state, packet store, reply sequencing and result register
module flpf_back (
	input logic clk,
	input logic arst_n,
	input logic [7:0] timeout_reload,
	input flpf_pkg::queue_head_t head,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic packet_complete,
	output logic checksum_ok,
	output logic last
);
	import flpf_pkg::*;

	typedef enum logic [2:0] {
		ST_CMD = 3'b001,
		ST_REPLY1 = 3'b010,
		ST_REPLY2 = 3'b100
	} step_t;

	logic [7:0] store_q [PACKET_BYTES];
	logic [IDX_W-1:0] wp_q;
	logic [7:0] sum_q;
	logic [7:0] tl_q;
	step_t step_q, step_d;

	logic out_valid_q;
	kind_t kind_q, kind_d;
	logic [7:0] data_q, data_d;
	logic complete_q, complete_d;
	logic ok_q, ok_d;
	logic last_q, last_d;

	logic out_free;
	logic load;
	logic send_start;
	logic [7:0] sum_base;
	logic wp_last;

	assign out_free = !out_valid_q || out_ready;
	assign sum_base = (wp_q == '0) ? 8'd0 : sum_q;
	assign wp_last = wp_q == IDX_W'(PACKET_BYTES - 1);

	always_comb begin
		pop = 1'b0;
		load = 1'b0;
		send_start = 1'b0;
		step_d = step_q;
		kind_d = KIND_STATUS;
		data_d = 8'd0;
		complete_d = 1'b0;
		ok_d = 1'b0;
		last_d = 1'b1;
		if (head.valid) begin
			unique case (step_q)
				ST_CMD: begin
					unique case (head.entry.op)
						OP_TICK: pop = 1'b1;
						OP_BYTE: begin
							if (out_free) begin
								pop = 1'b1;
								load = 1'b1;
								complete_d = wp_last;
								ok_d = wp_last && (sum_base == head.entry.data);
							end
						end
						OP_READ: begin
							if (out_free) begin
								pop = 1'b1;
								load = 1'b1;
								kind_d = KIND_READ;
								data_d = head.entry.rd_in_range ?
									store_q[head.entry.rd_idx] : 8'd0;
							end
						end
						OP_SEND: begin
							if (out_free) begin
								load = 1'b1;
								send_start = 1'b1;
								kind_d = KIND_REPLY;
								data_d = store_q[0];
								last_d = 1'b0;
								step_d = ST_REPLY1;
							end
						end
					endcase
				end
				ST_REPLY1: begin
					if (out_free) begin
						load = 1'b1;
						kind_d = KIND_REPLY;
						data_d = store_q[1];
						last_d = 1'b0;
						step_d = ST_REPLY2;
					end
				end
				ST_REPLY2: begin
					if (out_free) begin
						load = 1'b1;
						pop = 1'b1;
						kind_d = KIND_REPLY;
						data_d = store_q[2];
						step_d = ST_CMD;
					end
				end
				default: step_d = ST_CMD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			sum_q <= 8'd0;
			tl_q <= TIMEOUT_RESET;
			step_q <= ST_CMD;
			out_valid_q <= 1'b0;
			for (int k = 0; k < PACKET_BYTES; k++) store_q[k] <= 8'd0;
		end else begin
			step_q <= step_d;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (send_start) begin
				store_q[1] <= head.entry.data;
				store_q[2] <= store_q[0] + head.entry.data;
				for (int k = REPLY_BYTES; k < PACKET_BYTES; k++) store_q[k] <= 8'd0;
				wp_q <= '0;
				sum_q <= 8'd0;
			end else if (pop && head.entry.op == OP_BYTE) begin
				tl_q <= timeout_reload;
				store_q[wp_q] <= head.entry.data;
				if (wp_last) begin
					wp_q <= '0;
					sum_q <= sum_base;
				end else begin
					wp_q <= wp_q + 1'b1;
					sum_q <= sum_base + head.entry.data;
				end
			end else if (pop && head.entry.op == OP_TICK && tl_q != 8'd0) begin
				tl_q <= tl_q - 8'd1;
				if (tl_q == 8'd1) wp_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_d;
			data_q <= data_d;
			complete_q <= complete_d;
			ok_q <= ok_d;
			last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = kind_q;
	assign data_byte = data_q;
	assign packet_complete = complete_q;
	assign checksum_ok = ok_q;
	assign last = last_q;

	a_reply_holds_send: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != ST_CMD |-> head.valid && head.entry.op == OP_SEND)
		else $error("reply sequence without a send request at the queue head");

	a_ok_needs_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ok_q |-> complete_q && kind_q == KIND_STATUS)
		else $error("checksum flag on a result that closed no packet");

	a_reply_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ST_REPLY2 && out_free |=> step_q == ST_CMD && out_valid_q && last_q)
		else $error("reply did not end with its final byte");

	a_close_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.entry.op == OP_BYTE && wp_last |=> wp_q == '0)
		else $error("write index not rewound after a closed packet");

endmodule

### design/fixed_length_packet_framer.sv
`timescale 1ns / 1ps
// top level of the fixed-length packet framer
//
// requests come in on in_valid/in_ready with command, rx_byte, reply_byte and
// read_index; results leave on out_valid/out_ready with result_kind,
// data_byte, packet_complete, checksum_ok and last
// a received byte gives one status result, a timer tick gives none, a send
// gives three reply bytes and a read gives one stored byte
// a request is queued in a two-entry queue at acceptance; on an idle block its
// first result moves from the queue head to the output register; throughput is
// one request per cycle while out_ready stays high, but a send holds the
// executor for three reply bytes as the result register moves one byte a cycle
// the apb port holds timeout_reload at byte address 0, reset value 10
// reset clears the queue, the output register, framing state and the
// packet store at once; no clearing pass is needed
// while the receiver stalls the result register holds, the executor stops at
// the first request with a result, and in_ready falls once two are queued
module fixed_length_packet_framer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] command,
	input logic [7:0] rx_byte,
	input logic [7:0] reply_byte,
	input logic [3:0] read_index,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic packet_complete,
	output logic checksum_ok,
	output logic last,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import flpf_pkg::*;

	logic [7:0] reload_q;
	queue_head_t head;
	logic pop;
	logic reg_hit;

	assign pready = 1'b1;
	assign reg_hit = paddr[2] == REG_TIMEOUT_RELOAD;
	assign prdata = reg_hit ? {24'd0, reload_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			reload_q <= pwdata[7:0];
		end
	end

	flpf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.rx_byte(rx_byte),
		.reply_byte(reply_byte),
		.read_index(read_index),
		.head(head),
		.pop(pop)
	);

	flpf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.timeout_reload(reload_q),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.packet_complete(packet_complete),
		.checksum_ok(checksum_ok),
		.last(last)
	);

endmodule
